[sv/dld_pkg.sv]
// Shared types and codes for the deadlock detection block.
// Used by dld_cfg, dld_seq and the deadlock_detection top level; no dependencies.
package dld_pkg;

    // Item modes carried on the input tuser field.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_REQ   = 2'd1;
    localparam logic [1:0] MODE_AVAIL = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    // Result kinds.
    localparam logic KIND_FINISH  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Register indexes, taken from paddr[2].
    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    // Reset value of both count registers.
    localparam logic [4:0] COUNT_REG_RESET = 5'd16;

    // One input transaction.
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  process_index;
        logic [3:0]  resource_index;
        logic [15:0] count_value;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic       kind;
        logic [3:0] process_id;
        logic       deadlocked;
        logic       last;
    } result_t;

    // Configuration register contents.
    typedef struct packed {
        logic [4:0] process_count;
        logic [4:0] resource_count;
    } cfg_t;

endpackage

[sv/deadlock_detection.sv]
// Top level of the deadlock detection block: stream ports, result register, wiring.
// Depends on dld_pkg, dld_cfg and dld_seq (which holds dld_ram).
//
//   Channel   Direction  Signals                        Transaction
//   s_*       in         s_tvalid/s_tready/tdata/tuser  one load or run item
//   m_*       out        m_tvalid/m_tready/tdata/tuser  one finish or verdict result
//   APB       in         psel/penable/pwrite/paddr/...  count register access
//
// A load item writes one memory entry in the cycle it is accepted, one item per cycle
// while idle. A run copies the available counts into the work counts; each pass then scans
// the processes, checks each unfinished one (one table entry read per cycle) and, if it fits,
// adds its allocation and emits a finish; a pass without progress leads to the verdict.
// Reset clears the state machine, finish marks and the result register valid flag at once.
// A full result register holds the scan until m_tready takes the result.
module deadlock_detection #(
    parameter int unsigned MAX_PROCESSES = 16,
    parameter int unsigned MAX_RESOURCES = 16,
    parameter int unsigned COUNT_WIDTH   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] process_index, [7:4] resource_index, [23:8] count_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] process_id, [4] deadlocked, [7:5] zero
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dld_pkg::cfg_t    cfg;
    dld_pkg::item_t   item;
    dld_pkg::result_t res;
    dld_pkg::result_t out_reg;
    logic             res_valid;
    logic             res_ready;
    logic             out_valid_reg;

    // Unpack the input transaction.
    assign item.mode           = s_tuser;
    assign item.process_index  = s_tdata[3:0];
    assign item.resource_index = s_tdata[7:4];
    assign item.count_value    = s_tdata[23:8];

    dld_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dld_seq #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Result register: loads when empty or when its transaction completes.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Pack the output transaction.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.deadlocked, out_reg.process_id};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

[sv/dld_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies; instantiated twice by dld_seq.
module dld_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/dld_cfg.sv]
// APB-style register file holding the process and resource count registers.
// Depends on dld_pkg for the register indexes and the cfg_t type.
module dld_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output dld_pkg::cfg_t cfg
);

    logic [4:0] pc_reg;
    logic [4:0] rc_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes at the access cycle of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= dld_pkg::COUNT_REG_RESET;
            rc_reg <= dld_pkg::COUNT_REG_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                dld_pkg::REG_PROCESS_COUNT:  pc_reg <= pwdata[4:0];
                dld_pkg::REG_RESOURCE_COUNT: rc_reg <= pwdata[4:0];
                default:                     pc_reg <= pc_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        unique case (paddr[2])
            dld_pkg::REG_PROCESS_COUNT:  prdata = {27'd0, pc_reg};
            dld_pkg::REG_RESOURCE_COUNT: prdata = {27'd0, rc_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.process_count  = pc_reg;
    assign cfg.resource_count = rc_reg;

endmodule

[sv/dld_seq.sv]
// Detection sequencer: table and work memories, finish marks and the scan state machine.
// Depends on dld_pkg and dld_ram.
module dld_seq #(
    parameter int unsigned MAX_PROCESSES = 16,
    parameter int unsigned MAX_RESOURCES = 16,
    parameter int unsigned COUNT_WIDTH   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dld_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  dld_pkg::item_t   item,
    output logic             res_valid,
    input  logic             res_ready,
    output dld_pkg::result_t res
);

    localparam int unsigned PW   = $clog2(MAX_PROCESSES);
    localparam int unsigned PCW  = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned RCW  = $clog2(MAX_RESOURCES + 1);
    localparam int unsigned TDEP = 2 * MAX_PROCESSES * MAX_RESOURCES;
    localparam int unsigned TAW  = $clog2(TDEP);
    localparam int unsigned WDEP = 2 * MAX_RESOURCES;
    localparam int unsigned WAW  = $clog2(WDEP);
    localparam int unsigned REQ_BASE  = MAX_PROCESSES * MAX_RESOURCES;
    localparam int unsigned WORK_BASE = MAX_RESOURCES;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COPY    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_CHECK   = 3'd3;
    localparam logic [2:0] S_ADD     = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;
    localparam logic [2:0] S_FIND    = 3'd6;
    localparam logic [2:0] S_VERDICT = 3'd7;

    logic [2:0]               state_reg,    state_next;
    logic [PCW-1:0]           i_reg,        i_next;
    logic [RCW-1:0]           j_reg,        j_next;
    logic [RCW-1:0]           jd_reg,       jd_next;
    logic                     issue_reg,    issue_next;
    logic                     fit_reg,      fit_next;
    logic                     progress_reg, progress_next;
    logic                     dead_reg,     dead_next;
    logic [MAX_PROCESSES-1:0] fin_reg,      fin_next;

    logic [PCW-1:0]         np;
    logic [RCW-1:0]         nr;
    logic                   issue;
    logic                   phase_done;
    logic [PW-1:0]          i_idx;
    logic [COUNT_WIDTH-1:0] ld_value;
    logic                   ld_p_ok;
    logic                   ld_r_ok;
    logic                   in_fire;

    logic                   tbl_we;
    logic [TAW-1:0]         tbl_waddr;
    logic [TAW-1:0]         tbl_raddr;
    logic [COUNT_WIDTH-1:0] tbl_rdata;
    logic                   wk_we;
    logic [WAW-1:0]         wk_waddr;
    logic [COUNT_WIDTH-1:0] wk_wdata;
    logic [WAW-1:0]         wk_raddr;
    logic [COUNT_WIDTH-1:0] wk_rdata;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sum_sat;

    // Clamp the count registers to the table dimensions.
    assign np = (32'(cfg.process_count) > MAX_PROCESSES) ?
                PCW'(MAX_PROCESSES) : PCW'(cfg.process_count);
    assign nr = (32'(cfg.resource_count) > MAX_RESOURCES) ?
                RCW'(MAX_RESOURCES) : RCW'(cfg.resource_count);

    assign i_idx      = i_reg[PW-1:0];
    assign issue      = (j_reg < nr);
    assign phase_done = !issue && !issue_reg;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;

    // Load transaction decode.
    assign ld_value = COUNT_WIDTH'(item.count_value);
    assign ld_p_ok  = 32'(item.process_index) < MAX_PROCESSES;
    assign ld_r_ok  = 32'(item.resource_index) < MAX_RESOURCES;

    // Table memory: allocation rows first, request rows after them.
    assign tbl_waddr = TAW'(((item.mode == dld_pkg::MODE_REQ) ? REQ_BASE : 0) +
                            32'(item.process_index) * MAX_RESOURCES +
                            32'(item.resource_index));
    assign tbl_raddr = TAW'(((state_reg == S_CHECK) ? REQ_BASE : 0) +
                            32'(i_idx) * MAX_RESOURCES + 32'(j_reg));

    // Work memory: available counts first, work counts after them.
    assign wk_raddr = WAW'(((state_reg == S_COPY) ? 0 : WORK_BASE) + 32'(j_reg));

    // Saturating work update.
    assign sum     = {1'b0, wk_rdata} + {1'b0, tbl_rdata};
    assign sum_sat = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

    dld_ram #(
        .DEPTH (TDEP),
        .WIDTH (COUNT_WIDTH),
        .AW    (TAW)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (ld_value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    dld_ram #(
        .DEPTH (WDEP),
        .WIDTH (COUNT_WIDTH),
        .AW    (WAW)
    ) u_work_ram (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    // Next-state logic. Each memory phase issues one read per cycle and handles
    // the returned data in the cycle after; a phase ends only once its last read
    // has drained, so a work write never overlaps a read of the same entry.
    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        jd_next       = jd_reg;
        issue_next    = 1'b0;
        fit_next      = fit_reg;
        progress_next = progress_reg;
        dead_next     = dead_reg;
        fin_next      = fin_reg;
        tbl_we        = 1'b0;
        wk_we         = 1'b0;
        wk_waddr      = WAW'(WORK_BASE + 32'(jd_reg));
        wk_wdata      = sum_sat;
        res_valid     = 1'b0;
        res.kind       = dld_pkg::KIND_FINISH;
        res.process_id = 4'(i_reg);
        res.deadlocked = 1'b0;
        res.last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (item.mode)
                        dld_pkg::MODE_ALLOC,
                        dld_pkg::MODE_REQ:
                        begin
                            tbl_we = ld_p_ok && ld_r_ok;
                        end
                        dld_pkg::MODE_AVAIL:
                        begin
                            wk_we    = ld_r_ok;
                            wk_waddr = WAW'(32'(item.resource_index));
                            wk_wdata = ld_value;
                        end
                        dld_pkg::MODE_RUN:
                        begin
                            fin_next   = '0;
                            j_next     = '0;
                            state_next = S_COPY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_COPY:
            begin
                if (issue)
                begin
                    j_next     = RCW'(j_reg + 1'b1);
                    jd_next    = j_reg;
                    issue_next = 1'b1;
                end
                if (issue_reg)
                begin
                    wk_we    = 1'b1;
                    wk_wdata = wk_rdata;
                end
                if (phase_done)
                begin
                    i_next        = '0;
                    progress_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                priority if (i_reg >= np)
                begin
                    i_next        = '0;
                    progress_next = 1'b0;
                    if (!progress_reg)
                    begin
                        state_next = S_FIND;
                    end
                end
                else if (fin_reg[i_idx])
                begin
                    i_next = PCW'(i_reg + 1'b1);
                end
                else
                begin
                    j_next     = '0;
                    fit_next   = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (issue)
                begin
                    j_next     = RCW'(j_reg + 1'b1);
                    jd_next    = j_reg;
                    issue_next = 1'b1;
                end
                if (issue_reg && (tbl_rdata > wk_rdata))
                begin
                    fit_next = 1'b0;
                end
                if (phase_done)
                begin
                    j_next = '0;
                    if (fit_reg)
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        i_next     = PCW'(i_reg + 1'b1);
                        state_next = S_SCAN;
                    end
                end
            end

            S_ADD:
            begin
                if (issue)
                begin
                    j_next     = RCW'(j_reg + 1'b1);
                    jd_next    = j_reg;
                    issue_next = 1'b1;
                end
                if (issue_reg)
                begin
                    wk_we = 1'b1;
                end
                if (phase_done)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    fin_next[i_idx] = 1'b1;
                    progress_next   = 1'b1;
                    i_next          = PCW'(i_reg + 1'b1);
                    state_next      = S_SCAN;
                end
            end

            S_FIND:
            begin
                priority if (i_reg >= np)
                begin
                    dead_next  = 1'b0;
                    state_next = S_VERDICT;
                end
                else if (!fin_reg[i_idx])
                begin
                    dead_next  = 1'b1;
                    state_next = S_VERDICT;
                end
                else
                begin
                    i_next = PCW'(i_reg + 1'b1);
                end
            end

            S_VERDICT:
            begin
                res_valid      = 1'b1;
                res.kind       = dld_pkg::KIND_VERDICT;
                res.process_id = dead_reg ? 4'(i_reg) : 4'd0;
                res.deadlocked = dead_reg;
                res.last       = 1'b1;
                if (res_ready)
                begin
                    i_next     = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            jd_reg       <= '0;
            issue_reg    <= 1'b0;
            fit_reg      <= 1'b0;
            progress_reg <= 1'b0;
            dead_reg     <= 1'b0;
            fin_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            jd_reg       <= jd_next;
            issue_reg    <= issue_next;
            fit_reg      <= fit_next;
            progress_reg <= progress_next;
            dead_reg     <= dead_next;
            fin_reg      <= fin_next;
        end
    end

`ifndef ASSERT_OFF
    // A finish result never names a process that has already finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !fin_reg[i_idx])
    else $error("finish result for an already finished process");

    // A deadlock verdict names a process that never finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VERDICT && dead_reg) |-> (!fin_reg[i_idx] && i_reg < np))
    else $error("deadlock verdict names a finished process");

    // A memory phase is never left with a read still in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_COPY || state_reg == S_CHECK || state_reg == S_ADD) &&
         state_next != state_reg) |-> !issue_reg)
    else $error("memory phase left with a pending read");

    // The scan index never runs past the process limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(i_reg) <= MAX_PROCESSES)
    else $error("process index out of range");
`endif

endmodule
